// ----- hw/rtl/ttd_pkg.sv -----
// Package with shared constants and tables for the pose step block.
`default_nettype none
package ttd_pkg;
  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned GUARD_BITS        = 8;
  localparam int unsigned CFG_IDX_BITS      = 3;
  localparam int unsigned CFG_DATA_BITS     = 24;
  localparam int unsigned DIST_BITS         = 24;
  localparam int unsigned TURN_BITS         = 16;
  localparam int unsigned STEP_BITS         = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HDG  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIST_TOL    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_TOL   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_STEP  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_TURN_STEP   = 3'd6;

  localparam logic [1:0] ACT_ARRIVED = 2'd0;
  localparam logic [1:0] ACT_DRIVE   = 2'd1;
  localparam logic [1:0] ACT_FINAL   = 2'd2;

  localparam logic [31:0] GAIN_K = 32'h9B74EDA8;

  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/ttd_if.sv -----
// Valid/ready channel interfaces for pose input, command output and configuration.
`default_nettype none
interface ttd_pose_if #(parameter int unsigned POSITION_BITS = 24,
                        parameter int unsigned ANGLE_BITS = 16);
  logic valid;
  logic ready;
  logic signed [POSITION_BITS-1:0] current_x;
  logic signed [POSITION_BITS-1:0] current_y;
  logic signed [ANGLE_BITS-1:0]    current_heading;
  modport source (output valid, current_x, current_y, current_heading, input ready);
  modport sink   (input valid, current_x, current_y, current_heading, output ready);
endinterface

interface ttd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        turn_left;
  logic [15:0] turn_angle;
  logic [15:0] turn_periods;
  logic [23:0] drive_distance;
  logic [23:0] drive_periods;
  modport source (output valid, action, turn_left, turn_angle, turn_periods,
                  drive_distance, drive_periods, input ready);
  modport sink   (input valid, action, turn_left, turn_angle, turn_periods,
                  drive_distance, drive_periods, output ready);
endinterface

interface ttd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ttd_cordic_stage.sv -----
// One registered vectoring CORDIC micro-rotation with its side-band payload.
`default_nettype none
module ttd_cordic_stage #(
  parameter int unsigned XW = 42,
  parameter int unsigned SHIFT = 0,
  parameter int unsigned PW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [XW-1:0] in_x,
  input  wire logic signed [XW-1:0] in_y,
  input  wire logic [31:0]          in_z,
  input  wire logic [PW-1:0]        in_pay,
  output logic                      out_valid,
  output logic signed [XW-1:0]      out_x,
  output logic signed [XW-1:0]      out_y,
  output logic [31:0]               out_z,
  output logic [PW-1:0]             out_pay
);
  import ttd_pkg::*;
  localparam logic [31:0] ATAN = atan_entry(SHIFT);
  logic signed [XW-1:0] xs, ys;
  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pay <= in_pay;
      if (!in_y[XW-1]) begin
        out_x <= in_x + ys;
        out_y <= in_y - xs;
        out_z <= in_z + ATAN;
      end else begin
        out_x <= in_x - ys;
        out_y <= in_y + xs;
        out_z <= in_z - ATAN;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ttd_divider.sv -----
// Pipelined restoring ceiling divider, one quotient bit per stage.
`default_nettype none
module ttd_divider #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [NW-1:0]      quo
);
  localparam int unsigned RW = DW + 1;
  logic [NW-1:0] n_r [NW+1];
  logic [NW-1:0] q_r [NW+1];
  logic [RW-1:0] r_r [NW+1];
  logic [DW-1:0] d_r [NW+1];

  // Ceiling division: the floor quotient is raised by one when the remainder is nonzero.
  always_comb begin
    n_r[0] = num;
    q_r[0] = '0;
    r_r[0] = '0;
    d_r[0] = (den == '0) ? DW'(1) : den;
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [RW:0] trial;
    assign trial = {r_r[k], n_r[k][NW-1-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1] <= n_r[k];
        d_r[k+1] <= d_r[k];
        if (trial >= {1'b0, 1'b0, d_r[k]}) begin
          r_r[k+1] <= RW'(trial - {2'b00, d_r[k]});
          q_r[k+1] <= q_r[k] | (NW'(1) << (NW-1-k));
        end else begin
          r_r[k+1] <= RW'(trial);
          q_r[k+1] <= q_r[k];
        end
      end
    end
  end

  assign quo = q_r[NW] + NW'(r_r[NW] != '0);
endmodule
`default_nettype wire

// ----- hw/rtl/turn_then_drive_pose_step.sv -----
// Top level of the go-to-pose step pipeline: CORDIC, decision and period dividers.
//
//  Channel  Role  Payload
//  pose_in  sink  current_x, current_y, current_heading
//  cmd_out  src   action, turn_left, turn_angle, turn_periods, drive_*
//  cfg      sink  index, data (register write)
//
// One pose sample enters per cycle while the output is not stalled; the path runs through
// the CORDIC stages, the gain multiply and the 24-stage distance divider.
// The whole pipeline advances together and holds when the output is stalled.
// Synchronous reset clears valid bits and restores register defaults.
`default_nettype none
module turn_then_drive_pose_step #(
  parameter int unsigned POSITION_BITS = ttd_pkg::POSITION_BITS_DEF,
  parameter int unsigned ANGLE_BITS    = ttd_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = ttd_pkg::CORDIC_STAGES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ttd_pose_if.sink pose_in,
  ttd_cmd_if.source cmd_out,
  ttd_cfg_if.sink cfg
);
  import ttd_pkg::*;
  localparam int unsigned XW = POSITION_BITS + GUARD_BITS + 3;
  localparam int unsigned PW = ANGLE_BITS;
  localparam int unsigned NS = CORDIC_STAGES;

  logic signed [POSITION_BITS-1:0] tgt_x, tgt_y;
  logic [ANGLE_BITS-1:0] tgt_h;
  logic [DIST_BITS-1:0] dist_tol;
  logic [TURN_BITS-1:0] ang_tol;
  logic [STEP_BITS-1:0] drive_step, turn_step;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_x <= '0; tgt_y <= '0; tgt_h <= '0;
      dist_tol <= DIST_BITS'(819); ang_tol <= TURN_BITS'(1820);
      drive_step <= STEP_BITS'(205); turn_step <= STEP_BITS'(209);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TARGET_X:   tgt_x <= POSITION_BITS'(signed'(cfg.data));
        REG_TARGET_Y:   tgt_y <= POSITION_BITS'(signed'(cfg.data));
        REG_TARGET_HDG: tgt_h <= ANGLE_BITS'(cfg.data);
        REG_DIST_TOL:   dist_tol <= cfg.data;
        REG_ANGLE_TOL:  ang_tol <= cfg.data[15:0];
        REG_DRIVE_STEP: drive_step <= cfg.data[15:0];
        REG_TURN_STEP:  turn_step <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // Register stages in order: pre, cordic, gain, decide, divide and out.
  localparam int unsigned DIVL = DIST_BITS;
  localparam int unsigned LAT  = NS + 5 + DIVL;
  logic en;
  logic [LAT-1:0] vld;
  assign en = !cmd_out.valid || cmd_out.ready;
  assign pose_in.ready = en;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], pose_in.valid};
  end

  // Stage 0: differences and half-plane fold.
  logic signed [XW-1:0] x0, y0;
  logic [31:0] z0;
  logic [PW-1:0] h0;
  logic signed [POSITION_BITS-1:0] dx, dy;
  assign dx = tgt_x - pose_in.current_x;
  assign dy = tgt_y - pose_in.current_y;
  always_ff @(posedge clk) begin
    if (en) begin
      h0 <= pose_in.current_heading;
      if (dx < 0) begin
        x0 <= -(XW'(dx) <<< GUARD_BITS);
        y0 <= -(XW'(dy) <<< GUARD_BITS);
        z0 <= 32'h80000000;
      end else begin
        x0 <= XW'(dx) <<< GUARD_BITS;
        y0 <= XW'(dy) <<< GUARD_BITS;
        z0 <= '0;
      end
    end
  end

  logic signed [XW-1:0] cx [NS+1];
  logic signed [XW-1:0] cy [NS+1];
  logic [31:0] cz [NS+1];
  logic [PW-1:0] ch [NS+1];
  logic [NS:0] cv;
  assign cx[0] = x0; assign cy[0] = y0; assign cz[0] = z0; assign ch[0] = h0;
  assign cv[0] = vld[0];
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    ttd_cordic_stage #(.XW(XW), .SHIFT(i), .PW(PW)) u_st (
      .clk(clk), .rst(rst), .en(en), .in_valid(cv[i]),
      .in_x(cx[i]), .in_y(cy[i]), .in_z(cz[i]), .in_pay(ch[i]),
      .out_valid(cv[i+1]), .out_x(cx[i+1]), .out_y(cy[i+1]),
      .out_z(cz[i+1]), .out_pay(ch[i+1]));
  end

  // Gain removal: two partial products with the 16-bit gain halves, then sum and round.
  localparam int unsigned UW = XW - 1;
  logic [UW-1:0] ux;
  assign ux = cx[NS][XW-1] ? '0 : cx[NS][UW-1:0];
  logic [UW+15:0] ph, pl;
  logic [31:0] zg1, zg2;
  logic [PW-1:0] hg1, hg2;
  logic [UW+16:0] tsum;
  always_ff @(posedge clk) begin
    if (en) begin
      ph <= ux * GAIN_K[31:16];
      pl <= ux * GAIN_K[15:0];
      zg1 <= cz[NS]; hg1 <= ch[NS];
      tsum <= (UW+17)'(ph) + (UW+17)'(pl >> 16);
      zg2 <= zg1; hg2 <= hg1;
    end
  end
  logic [UW+16:0] dist_full;
  assign dist_full = (tsum + (UW+17)'(64'd1 << (15 + GUARD_BITS))) >> (16 + GUARD_BITS);
  logic [ANGLE_BITS-1:0] bear;
  assign bear = ANGLE_BITS'((33'(zg2) + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS));

  // Decision stage.
  logic [ANGLE_BITS-1:0] herr, berr, turn;
  logic [ANGLE_BITS-1:0] hmag, tmag_a;
  logic [1:0] act;
  logic [DIST_BITS-1:0] dd;
  assign herr = tgt_h - hg2;
  assign berr = bear - hg2;
  assign hmag = herr[ANGLE_BITS-1] ? -herr : herr;
  logic dlt, dgt;
  assign dlt = dist_full < (UW+17)'(dist_tol);
  assign dgt = dist_full > (UW+17)'(dist_tol);
  always_comb begin
    if (dlt && (32'(hmag) < 32'(ang_tol))) begin
      act = ACT_ARRIVED; turn = '0; dd = '0;
    end else if (dgt) begin
      act = ACT_DRIVE; turn = berr;
      dd = (dist_full > (UW+17)'({DIST_BITS{1'b1}})) ? '1 : DIST_BITS'(dist_full);
    end else begin
      act = ACT_FINAL; turn = herr; dd = '0;
    end
    tmag_a = turn[ANGLE_BITS-1] ? -turn : turn;
  end
  logic [1:0] act3;
  logic left3;
  logic [TURN_BITS-1:0] tmag3;
  logic [DIST_BITS-1:0] dd3;
  always_ff @(posedge clk) begin
    if (en) begin
      act3 <= act;
      left3 <= !turn[ANGLE_BITS-1] && turn != '0;
      tmag3 <= (32'(tmag_a) > 32'({TURN_BITS{1'b1}})) ? '1 : TURN_BITS'(tmag_a);
      dd3 <= dd;
    end
  end

  logic [DIST_BITS-1:0] dq;
  logic [TURN_BITS-1:0] tq;
  ttd_divider #(.NW(DIST_BITS), .DW(STEP_BITS)) u_ddiv (
    .clk(clk), .en(en), .num(dd3), .den(drive_step), .quo(dq));
  ttd_divider #(.NW(TURN_BITS), .DW(STEP_BITS)) u_tdiv (
    .clk(clk), .en(en), .num(tmag3), .den(turn_step), .quo(tq));

  // Delay lines to align with the dividers.
  logic [1:0] act_d [DIVL+1];
  logic left_d [DIVL+1];
  logic [TURN_BITS-1:0] tm_d [DIVL+1];
  logic [DIST_BITS-1:0] dd_d [DIVL+1];
  logic [TURN_BITS-1:0] tq_d [DIVL-TURN_BITS+1];
  assign act_d[0] = act3; assign left_d[0] = left3; assign tm_d[0] = tmag3;
  assign dd_d[0] = dd3; assign tq_d[0] = tq;
  for (genvar k = 0; k < DIVL; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        act_d[k+1] <= act_d[k]; left_d[k+1] <= left_d[k];
        tm_d[k+1] <= tm_d[k]; dd_d[k+1] <= dd_d[k];
      end
    end
  end
  for (genvar k = 0; k < DIVL - TURN_BITS; k++) begin : g_tq_dly
    always_ff @(posedge clk) begin
      if (en) begin
        tq_d[k+1] <= tq_d[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_out.action <= act_d[DIVL];
      cmd_out.turn_left <= left_d[DIVL];
      cmd_out.turn_angle <= tm_d[DIVL];
      cmd_out.turn_periods <= tq_d[DIVL-TURN_BITS];
      cmd_out.drive_distance <= dd_d[DIVL];
      cmd_out.drive_periods <= dq;
    end
  end
  assign cmd_out.valid = vld[LAT-1];
endmodule
`default_nettype wire

// ----- verif/turn_then_drive_pose_step_test.sv -----
// Self-checking testbench for the go-to-pose step block with its own command predictor.
`default_nettype none
module turn_then_drive_pose_step_test;
  import ttd_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int LATENCY = CORDIC_STAGES_DEF + 29;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  action;
    logic        turn_left;
    logic [15:0] turn_angle;
    logic [15:0] turn_periods;
    logic [23:0] drive_distance;
    logic [23:0] drive_periods;
  } command_t;

  logic clk;
  logic rst;
  longint cycle_count;

  ttd_pose_if #(.POSITION_BITS(24), .ANGLE_BITS(16)) pose ();
  ttd_cmd_if cmd ();
  ttd_cfg_if cfg_ch ();

  turn_then_drive_pose_step uut (
    .clk(clk), .rst(rst), .pose_in(pose), .cmd_out(cmd), .cfg(cfg_ch)
  );

  logic [23:0] goal_x, goal_y, dist_tol;
  logic [15:0] goal_heading, angle_tol, drive_step, turn_step;

  command_t expected_cmds[$];
  int mismatches;
  bit sender_calm, receiver_calm;
  int hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("turn_then_drive_pose_step_test: errors");
        $finish;
      end
    end
  end

  function automatic longint unsigned ceil_periods(longint unsigned a, logic [15:0] s);
    longint unsigned d;
    d = (s == 16'd0) ? 1 : longint'(s);
    return (a + d - 1) / d;
  endfunction

  function automatic command_t predict_command(logic [23:0] cx, logic [23:0] cy,
                                               logic [15:0] ch);
    command_t r;
    logic [23:0] ddx, ddy;
    logic [15:0] hd, td;
    logic [31:0] z;
    longint dx, dy, x, y, nx, herr, turn;
    longint unsigned ux, t, distance, bear, hmag, tmag, dd;
    ddx = goal_x - cx;
    ddy = goal_y - cy;
    dx = signed'(ddx);
    dy = signed'(ddy);
    z = 32'd0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      z = 32'h80000000;
    end
    x = dx * 256;
    y = dy * 256;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_entry(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_entry(i);
      end
      x = nx;
    end
    ux = (x < 0) ? 0 : x;
    t = ux * longint'(GAIN_K[31:16]) + ((ux * longint'(GAIN_K[15:0])) >> 16);
    distance = (t + (64'd1 << 23)) >> 24;
    bear = ((longint'(z) + (64'd1 << 15)) >> 16) & 64'hFFFF;
    hd = goal_heading - ch;
    herr = signed'(hd);
    hmag = (herr < 0) ? -herr : herr;
    dd = 0;
    turn = 0;
    if (distance < dist_tol && hmag < angle_tol) begin
      r.action = ACT_ARRIVED;
    end else if (distance > dist_tol) begin
      r.action = ACT_DRIVE;
      td = bear[15:0] - ch;
      turn = signed'(td);
      dd = (distance > 64'hFFFFFF) ? 64'hFFFFFF : distance;
    end else begin
      r.action = ACT_FINAL;
      turn = herr;
    end
    tmag = (turn < 0) ? -turn : turn;
    if (tmag > 64'hFFFF) tmag = 64'hFFFF;
    r.turn_left = (turn > 0);
    r.turn_angle = tmag[15:0];
    r.turn_periods = 16'(ceil_periods(tmag, turn_step));
    r.drive_distance = dd[23:0];
    r.drive_periods = 24'(ceil_periods(dd, drive_step));
    return r;
  endfunction

  // Receiver: draws a random stall after each transfer unless calm, and honours long hold requests.
  initial begin
    int wait_left;
    command_t want;
    wait_left = 0;
    cmd.ready = 1'b0;
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (!rst && cmd.valid && cmd.ready) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected command %p", cmd.action);
        end else begin
          want = expected_cmds.pop_front();
          if (want !== {cmd.action, cmd.turn_left, cmd.turn_angle, cmd.turn_periods,
                        cmd.drive_distance, cmd.drive_periods}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got act=%0d left=%0d ang=%0d tp=%0d dd=%0d dp=%0d",
                       want, cmd.action, cmd.turn_left, cmd.turn_angle,
                       cmd.turn_periods, cmd.drive_distance, cmd.drive_periods);
          end
        end
        wait_left = receiver_calm ? 0 : $urandom_range(0, 6);
      end
      if (hold_request > 0) begin
        wait_left = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        cmd.ready <= 1'b0;
      end else if (wait_left > 0) begin
        cmd.ready <= 1'b0;
        wait_left--;
      end else begin
        cmd.ready <= 1'b1;
      end
    end
  end

  task automatic send_pose(logic [23:0] cx, logic [23:0] cy, logic [15:0] ch);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pose.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pose.valid <= 1'b1;
    pose.current_x <= cx;
    pose.current_y <= cy;
    pose.current_heading <= ch;
    do @(posedge clk); while (!pose.ready);
    expected_cmds.push_back(predict_command(cx, cy, ch));
  endtask

  task automatic drain;
    pose.valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_X:   goal_x = value;
      REG_TARGET_Y:   goal_y = value;
      REG_TARGET_HDG: goal_heading = value[15:0];
      REG_DIST_TOL:   dist_tol = value;
      REG_ANGLE_TOL:  angle_tol = value[15:0];
      REG_DRIVE_STEP: drive_step = value[15:0];
      REG_TURN_STEP:  turn_step = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_random_pose;
    logic [23:0] cx, cy;
    logic [15:0] ch;
    int shape;
    shape = $urandom_range(0, 9);
    cx = 24'($urandom);
    cy = 24'($urandom);
    ch = 16'($urandom);
    if (shape < 4) begin
      cx = goal_x + 24'($signed($urandom_range(0, 4000)) - 2000);
      cy = goal_y + 24'($signed($urandom_range(0, 4000)) - 2000);
      ch = goal_heading + 16'($signed($urandom_range(0, 8000)) - 4000);
    end else if (shape < 6) begin
      cx = goal_x + 24'($signed($urandom_range(0, 200000)) - 100000);
      cy = goal_y + 24'($signed($urandom_range(0, 200000)) - 100000);
    end
    send_pose(cx, cy, ch);
  endtask

  task automatic test_directed;
    send_pose(24'h000000, 24'h000000, 16'h0000);
    send_pose(24'h000000, 24'h000000, 16'h8000);
    send_pose(24'h000000, 24'h000000, 16'h7FFF);
    send_pose(24'h000000, 24'h000000, 16'd1820);
    send_pose(24'h000000, 24'h000000, -16'sd1819);
    send_pose(24'd819, 24'h000000, 16'h0000);
    send_pose(24'd818, 24'h000000, 16'h0000);
    send_pose(24'd900, 24'h000000, 16'h0000);
    send_pose(24'h800000, 24'h800000, 16'h8000);
    send_pose(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
    send_pose(24'h800000, 24'h000000, 16'h4000);
    send_pose(24'h000000, 24'h7FFFFF, 16'hC000);
    send_pose(24'hFFFFFF, 24'h000001, 16'h0001);
    send_pose(24'h001000, 24'hFFF000, 16'hFFFF);
    send_pose(24'h5A5A5A, 24'hA5A5A5, 16'h5A5A);
    drain();
  endtask

  task automatic test_register_extremes;
    write_reg(REG_DRIVE_STEP, 24'd0);
    write_reg(REG_TURN_STEP, 24'd0);
    write_reg(REG_DIST_TOL, 24'd0);
    write_reg(REG_ANGLE_TOL, 24'd0);
    write_reg(REG_UNUSED, 24'hABCDEF);
    for (int i = 0; i < 8; i++) send_random_pose();
    send_pose(24'h000000, 24'h000000, 16'h0000);
    drain();
    write_reg(REG_TARGET_X, 24'h7FFFFF);
    write_reg(REG_TARGET_Y, 24'h800000);
    write_reg(REG_TARGET_HDG, 24'h008000);
    write_reg(REG_DIST_TOL, 24'hFFFFFF);
    write_reg(REG_ANGLE_TOL, 24'h008000);
    write_reg(REG_DRIVE_STEP, 24'h00FFFF);
    write_reg(REG_TURN_STEP, 24'h008000);
    send_pose(24'h7FFFFF, 24'h800000, 16'h0000);
    send_pose(24'h7FFFFF, 24'h800000, 16'h8000);
    send_pose(24'h800000, 24'h7FFFFF, 16'h1234);
    for (int i = 0; i < 8; i++) send_random_pose();
    drain();
    write_reg(REG_DIST_TOL, 24'd1);
    write_reg(REG_ANGLE_TOL, 24'd1);
    write_reg(REG_DRIVE_STEP, 24'd1);
    write_reg(REG_TURN_STEP, 24'd1);
    for (int i = 0; i < 10; i++) send_random_pose();
    drain();
  endtask

  task automatic test_random_phases;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_TARGET_X, 24'($urandom));
      write_reg(REG_TARGET_Y, 24'($urandom));
      write_reg(REG_TARGET_HDG, 24'($urandom));
      write_reg(REG_DIST_TOL, (phase % 2) ? 24'($urandom_range(0, 5000)) : 24'($urandom));
      write_reg(REG_ANGLE_TOL, 24'($urandom_range(0, 32768)));
      write_reg(REG_DRIVE_STEP, 24'($urandom_range(0, 65535)));
      write_reg(REG_TURN_STEP, 24'($urandom_range(0, 32768)));
      sender_calm = (phase == 2);
      receiver_calm = (phase == 2 || phase == 4);
      for (int i = 0; i < 200; i++) send_random_pose();
      drain();
    end
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  task automatic test_backpressure;
    sender_calm = 1'b1;
    hold_request = 300;
    for (int i = 0; i < 150; i++) send_random_pose();
    sender_calm = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    pose.valid = 1'b0;
    pose.current_x = '0;
    pose.current_y = '0;
    pose.current_heading = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    hold_request = 0;
    goal_x = '0;
    goal_y = '0;
    goal_heading = '0;
    dist_tol = 24'd819;
    angle_tol = 16'd1820;
    drive_step = 16'd205;
    turn_step = 16'd209;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    if (mismatches == 0) begin
      $display("turn_then_drive_pose_step_test: clean");
    end else begin
      $display("turn_then_drive_pose_step_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/ttd_pkg.sv
hw/rtl/ttd_if.sv
hw/rtl/ttd_cordic_stage.sv
hw/rtl/ttd_divider.sv
hw/rtl/turn_then_drive_pose_step.sv
verif/turn_then_drive_pose_step_test.sv
